[rtl/ivle_pkg.sv]
// Shared types and codes for the integer list engine.
package ivle_pkg;

    // Operation codes carried in the opcode field
    localparam logic [3:0] OP_APPEND     = 4'd0;
    localparam logic [3:0] OP_INSERT     = 4'd1;
    localparam logic [3:0] OP_ERASE_AT   = 4'd2;
    localparam logic [3:0] OP_ERASE_VAL  = 4'd3;
    localparam logic [3:0] OP_ERASE_EVEN = 4'd4;
    localparam logic [3:0] OP_RESIZE     = 4'd5;
    localparam logic [3:0] OP_CLEAR      = 4'd6;
    localparam logic [3:0] OP_SORT       = 4'd7;
    localparam logic [3:0] OP_READ       = 4'd8;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_INDEX = 2'd2;
    localparam logic [1:0] ST_SIZE  = 2'd3;

    typedef struct packed {
        logic [3:0]         opcode;
        logic [6:0]         position;
        logic signed [31:0] operand_value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [6:0]         element_count;
        logic [6:0]         removed_count;
        logic signed [31:0] read_value;
    } out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic read;
        logic step;
        logic finish;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic loop_done;
    } dp_stat_t;

endpackage

[rtl/int_vector_list_engine_core.sv]
// Top level of the integer list engine.
//
// Input channel s_valid/s_ready/s_word carries one operation word (opcode,
// position, operand_value); the result channel m_valid/m_ready/m_word gives
// one word per operation: status, element count, removed count, read value.
// One operation is in progress at a time; s_ready is high only while idle.
// Append, resize-shrink, clear, errors and unused codes finish without a
// memory loop; read, insert, erase at / value / even, resize grow and sort
// step through memory, sort as bubble passes over a shrinking range.
// Every loop step is a memory read followed by at most one write, set by the one
// read and one write port of the element memory.
// The result sits in an output register, so the next word is taken while a
// result waits; a finished operation holds in place until that register frees.
// Reset empties the list and drops any pending result; memory is not cleared.
module int_vector_list_engine_core #(
    parameter int DEPTH         = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ivle_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output ivle_pkg::out_word_t m_word
);
    import ivle_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ivle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    ivle_dp #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_word  (s_word),
        .cmd     (cmd),
        .stat    (stat),
        .m_word  (m_word)
    );

endmodule

[rtl/ivle_ctrl.sv]
// Sequencing state machine for the integer list engine.
module ivle_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output ivle_pkg::dp_cmd_t  cmd,
    input  ivle_pkg::dp_stat_t stat
);
    import ivle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_STEP = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign s_ready  = (state_reg == S_IDLE);

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                if (stat.loop_done) begin
                    if (out_free) begin
                        cmd.finish   = 1'b1;
                        m_valid_next = 1'b1;
                        state_next   = S_IDLE;
                    end
                end else begin
                    cmd.read   = 1'b1;
                    state_next = S_STEP;
                end
            end
            S_STEP: begin
                cmd.step   = 1'b1;
                state_next = S_RUN;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[rtl/ivle_dp.sv]
// Datapath of the integer list engine: element memory, pointers, result register.
module ivle_dp #(
    parameter int DEPTH         = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ivle_pkg::in_word_t  s_word,
    input  ivle_pkg::dp_cmd_t   cmd,
    output ivle_pkg::dp_stat_t  stat,
    output ivle_pkg::out_word_t m_word
);
    import ivle_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int XW = (CW > 7) ? CW : 7;
    localparam int EW = ELEMENT_WIDTH;

    logic [EW-1:0] mem [DEPTH];
    logic signed [EW-1:0] rdata_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rp_reg, rp_next;
    logic [CW-1:0] wp_reg, wp_next;
    logic [CW-1:0] pend_reg, pend_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [3:0]    op_reg, op_next;
    logic [1:0]    st_reg, st_next;
    logic signed [EW-1:0] val_reg, val_next;
    logic signed [EW-1:0] cur_reg, cur_next;
    logic signed [31:0]   rd_reg, rd_next;
    out_word_t     out_reg, out_next;

    logic          we;
    logic [AW-1:0] wa, ra;
    logic [EW-1:0] wd;
    logic [CW-1:0] removed;
    logic [XW-1:0] pos_x, cnt_x;
    logic          full, hit;

    assign pos_x  = XW'(s_word.position);
    assign cnt_x  = XW'(count_reg);
    assign full   = (count_reg == CW'(DEPTH));
    assign m_word = out_reg;

    // Read address: insert walks down reading one below the write slot
    assign ra = (op_reg == OP_INSERT) ? AW'(rp_reg - 1'b1) : AW'(rp_reg);

    // Compaction hit test
    always_comb begin
        case (op_reg)
            OP_ERASE_AT:  hit = (rp_reg == pos_reg);
            OP_ERASE_VAL: hit = (rdata_reg == val_reg);
            default:      hit = !rdata_reg[0];
        endcase
    end

    // Loop completion per operation
    always_comb begin
        stat.loop_done = 1'b1;
        if (st_reg == ST_OK) begin
            case (op_reg)
                OP_APPEND, OP_INSERT: stat.loop_done = (rp_reg == pos_reg);
                OP_ERASE_AT, OP_ERASE_VAL, OP_ERASE_EVEN:
                    stat.loop_done = (rp_reg == count_reg);
                OP_RESIZE: stat.loop_done = (wp_reg >= pos_reg);
                OP_SORT:   stat.loop_done = (pend_reg <= CW'(1));
                OP_READ:   stat.loop_done = (wp_reg != '0);
                default:   stat.loop_done = 1'b1;
            endcase
        end
    end

    // Working register updates
    always_comb begin
        count_next = count_reg;
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        pend_next  = pend_reg;
        pos_next   = pos_reg;
        op_next    = op_reg;
        st_next    = st_reg;
        val_next   = val_reg;
        cur_next   = cur_reg;
        rd_next    = rd_reg;
        out_next   = out_reg;
        removed    = '0;
        we         = 1'b0;
        wa         = AW'(wp_reg);
        wd         = rdata_reg;

        if (cmd.load) begin
            op_next   = s_word.opcode;
            val_next  = EW'(s_word.operand_value);
            pos_next  = CW'(s_word.position);
            st_next   = ST_OK;
            rd_next   = '0;
            rp_next   = '0;
            wp_next   = '0;
            pend_next = count_reg;
            case (s_word.opcode)
                OP_APPEND: begin
                    if (full) st_next = ST_FULL;
                    pos_next = count_reg;
                    rp_next  = count_reg;
                end
                OP_INSERT: begin
                    if (full) st_next = ST_FULL;
                    else if (pos_x > cnt_x) st_next = ST_INDEX;
                    rp_next = count_reg;
                end
                OP_ERASE_AT, OP_READ: begin
                    if (pos_x >= cnt_x) st_next = ST_INDEX;
                    if (s_word.opcode == OP_READ) rp_next = CW'(s_word.position);
                end
                OP_RESIZE: begin
                    if (pos_x > XW'(DEPTH)) st_next = ST_SIZE;
                    wp_next = count_reg;
                end
                default: ;
            endcase
        end

        if (cmd.step) begin
            case (op_reg)
                OP_APPEND, OP_INSERT: begin
                    we      = 1'b1;
                    wa      = AW'(rp_reg);
                    rp_next = rp_reg - 1'b1;
                end
                OP_ERASE_AT, OP_ERASE_VAL, OP_ERASE_EVEN: begin
                    if (!hit) begin
                        we      = 1'b1;
                        wp_next = wp_reg + 1'b1;
                    end
                    rp_next = rp_reg + 1'b1;
                end
                OP_RESIZE: begin
                    we      = 1'b1;
                    wd      = '0;
                    wp_next = wp_reg + 1'b1;
                end
                OP_SORT: begin
                    // Bubble pass carrying the running maximum in cur
                    if (rp_reg == '0) begin
                        cur_next = rdata_reg;
                        rp_next  = rp_reg + 1'b1;
                    end else if (rp_reg < pend_reg) begin
                        we = 1'b1;
                        wa = AW'(rp_reg - 1'b1);
                        if (cur_reg <= rdata_reg) begin
                            wd       = cur_reg;
                            cur_next = rdata_reg;
                        end
                        rp_next = rp_reg + 1'b1;
                    end else begin
                        we        = 1'b1;
                        wa        = AW'(pend_reg - 1'b1);
                        wd        = cur_reg;
                        pend_next = pend_reg - 1'b1;
                        rp_next   = '0;
                    end
                end
                OP_READ: begin
                    rd_next = 32'(rdata_reg);
                    wp_next = CW'(1);
                end
                default: ;
            endcase
        end

        if (cmd.finish) begin
            if (st_reg == ST_OK) begin
                case (op_reg)
                    OP_APPEND, OP_INSERT: begin
                        we         = 1'b1;
                        wa         = AW'(pos_reg);
                        wd         = val_reg;
                        count_next = count_reg + 1'b1;
                    end
                    OP_ERASE_AT, OP_ERASE_VAL, OP_ERASE_EVEN: begin
                        removed    = count_reg - wp_reg;
                        count_next = wp_reg;
                    end
                    OP_RESIZE: begin
                        if (count_reg > pos_reg) removed = count_reg - pos_reg;
                        count_next = pos_reg;
                    end
                    OP_CLEAR: begin
                        removed    = count_reg;
                        count_next = '0;
                    end
                    default: ;
                endcase
            end
            out_next.status        = st_reg;
            out_next.element_count = 7'(count_next);
            out_next.removed_count = 7'(removed);
            out_next.read_value    = rd_reg;
        end
    end

    // Element memory, registered read
    always_ff @(posedge aclk) begin
        if (we) mem[wa] <= wd;
        if (cmd.read) rdata_reg <= mem[ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            st_reg    <= ST_OK;
            op_reg    <= OP_CLEAR;
        end else begin
            count_reg <= count_next;
            st_reg    <= st_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge aclk) begin
        rp_reg   <= rp_next;
        wp_reg   <= wp_next;
        pend_reg <= pend_next;
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        cur_reg  <= cur_next;
        rd_reg   <= rd_next;
        out_reg  <= out_next;
    end

endmodule

[rtl/ivle_checker.sv]
// Port-level assertions for the integer list engine, bound to the top level.
module ivle_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input ivle_pkg::out_word_t m_word,
    input logic                m_valid,
    input logic                m_ready
);
    import ivle_pkg::*;

    // A pending result word is not withdrawn
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // One operation at a time: input closes right after a word is taken
    a_one_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while busy");

    // Reset drops any result
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A flagged operation removes nothing and reads nothing
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.status != ST_OK |->
            m_word.removed_count == 7'd0 && m_word.read_value == 32'sd0)
        else $error("flagged operation reported a change");

endmodule

bind int_vector_list_engine_core ivle_checker u_ivle_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_word  (m_word),
    .m_valid (m_valid),
    .m_ready (m_ready)
);

[tb/sv/int_vector_list_engine_core_tb.sv]
// Testbench for the integer list engine: random list operations checked against a list model.
module int_vector_list_engine_core_tb;
    import ivle_pkg::*;

    localparam int LIST_DEPTH = 64;
    localparam int WORD_TARGET = 1150;

    // Scoreboard: keeps a copy of the list and the queue of expected result words
    class list_scoreboard;
        logic signed [31:0] elems[$];
        out_word_t          pending[$];
        int                 mismatches;

        function void note_word(in_word_t w);
            out_word_t          r;
            logic signed [31:0] e;
            int                 i;
            int                 j;
            r = '0;
            r.status = ST_OK;
            case (w.opcode)
                OP_APPEND: begin
                    if (elems.size() >= LIST_DEPTH) r.status = ST_FULL;
                    else elems.insert(elems.size(), w.operand_value);
                end
                OP_INSERT: begin
                    if (elems.size() >= LIST_DEPTH) r.status = ST_FULL;
                    else if (w.position > elems.size()) r.status = ST_INDEX;
                    else elems.insert(w.position, w.operand_value);
                end
                OP_ERASE_AT: begin
                    if (w.position >= elems.size()) r.status = ST_INDEX;
                    else begin
                        elems.delete(w.position);
                        r.removed_count = 7'd1;
                    end
                end
                OP_ERASE_VAL, OP_ERASE_EVEN: begin
                    i = 0;
                    while (i < elems.size()) begin
                        if ((w.opcode == OP_ERASE_VAL) ? (elems[i] == w.operand_value)
                                                       : (elems[i][0] == 1'b0)) begin
                            elems.delete(i);
                            r.removed_count++;
                        end else begin
                            i++;
                        end
                    end
                end
                OP_RESIZE: begin
                    if (w.position > LIST_DEPTH) r.status = ST_SIZE;
                    else begin
                        if (w.position < elems.size())
                            r.removed_count = 7'(elems.size() - w.position);
                        while (elems.size() > w.position) void'(elems.pop_back());
                        while (elems.size() < w.position) elems.insert(elems.size(), 32'sd0);
                    end
                end
                OP_CLEAR: begin
                    r.removed_count = 7'(elems.size());
                    elems.delete();
                end
                OP_SORT: begin
                    // insertion sort on the signed value
                    for (i = 1; i < elems.size(); i++) begin
                        e = elems[i];
                        j = i;
                        while (j > 0 && elems[j-1] > e) begin
                            elems[j] = elems[j-1];
                            j--;
                        end
                        elems[j] = e;
                    end
                end
                OP_READ: begin
                    if (w.position >= elems.size()) r.status = ST_INDEX;
                    else r.read_value = elems[w.position];
                end
                default: ;
            endcase
            r.element_count = 7'(elems.size());
            pending.insert(pending.size(), r);
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.element_count !== want.element_count ||
                got.removed_count !== want.removed_count ||
                got.read_value !== want.read_value) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: want st=%0d cnt=%0d rm=%0d rd=%0d, ",
                              "got st=%0d cnt=%0d rm=%0d rd=%0d"},
                             want.status, want.element_count, want.removed_count,
                             want.read_value, got.status, got.element_count,
                             got.removed_count, got.read_value);
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_word;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_word;

    list_scoreboard board;
    int             burst_left;

    int_vector_list_engine_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Random operand: extremes, full-range values, or small values in -4..3 so erase-value hits
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2, 3:    return $signed($urandom());
            default: return $signed(32'($urandom_range(0, 7)) - 32'sd4);
        endcase
    endfunction

    // Send one word; sender gaps come between bursts, valid stays up inside a burst
    task automatic send_word(input logic [3:0] op, input logic [6:0] pos,
                             input logic signed [31:0] val);
        in_word_t w;
        w.opcode = op;
        w.position = pos;
        w.operand_value = val;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_word  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_word(w);
        if (burst_left == 0) s_valid <= 1'b0;
    endtask

    // Close an open burst so the sender goes quiet
    task automatic hold_input();
        if (burst_left != 0) begin
            s_valid <= 1'b0;
            burst_left = 0;
        end
    endtask

    // Random word biased toward keeping the list mid-full
    task automatic send_random();
        int          n;
        int          k;
        logic [3:0]  op;
        logic [6:0]  pos;
        n = board.elems.size();
        k = $urandom_range(0, 99);
        if (k < 30) op = OP_APPEND;
        else if (k < 45) op = OP_INSERT;
        else if (k < 55) op = OP_ERASE_AT;
        else if (k < 62) op = OP_ERASE_VAL;
        else if (k < 65) op = OP_ERASE_EVEN;
        else if (k < 70) op = OP_RESIZE;
        else if (k < 72) op = OP_CLEAR;
        else if (k < 76) op = OP_SORT;
        else if (k < 96) op = OP_READ;
        else op = 4'($urandom_range(9, 15));
        if ($urandom_range(0, 9) == 0) pos = 7'($urandom_range(0, 127));
        else pos = 7'($urandom_range(0, (n < 64) ? n : 64));
        send_word(op, pos, pick_value());
    endtask

    // Receiver stall pattern: alternating ready stretches and stalls
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            if ($urandom_range(0, 2) != 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_word(m_word);
    end

    initial begin
        int i;
        board = new();
        s_valid = 1'b0;
        s_word = '0;
        aresetn = 1'b0;
        burst_left = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty-list errors, extremes, full list, every operation
        send_word(OP_READ, 7'd0, 0);
        send_word(OP_ERASE_AT, 7'd0, 0);
        send_word(OP_INSERT, 7'd1, 5);
        send_word(OP_APPEND, 7'd0, 32'sh7fffffff);
        send_word(OP_INSERT, 7'd0, 32'sh80000000);
        send_word(OP_INSERT, 7'd2, -1);
        send_word(OP_SORT, 7'd0, 0);
        send_word(OP_READ, 7'd0, 0);
        send_word(OP_READ, 7'd2, 0);
        send_word(OP_READ, 7'd3, 0);
        send_word(OP_ERASE_VAL, 7'd0, -1);
        send_word(OP_ERASE_EVEN, 7'd0, 0);
        send_word(OP_RESIZE, 7'd65, 0);
        send_word(OP_RESIZE, 7'd127, 0);
        send_word(OP_RESIZE, 7'd64, 0);
        send_word(OP_APPEND, 7'd0, 3);
        send_word(OP_INSERT, 7'd70, 3);
        send_word(OP_READ, 7'd63, 0);
        send_word(OP_RESIZE, 7'd2, 0);
        send_word(OP_ERASE_AT, 7'd1, 0);
        send_word(4'd9, 7'd0, 0);
        send_word(4'd15, 7'h7f, -1);
        send_word(OP_CLEAR, 7'd0, 0);
        send_word(OP_RESIZE, 7'd0, 0);

        // Hold off until every result has come back
        hold_input();
        while (board.pending.size() != 0) @(posedge aclk);

        for (i = 0; i < WORD_TARGET; i++) begin
            send_random();
            if (i == WORD_TARGET / 2) begin
                hold_input();
                while (board.pending.size() != 0) @(posedge aclk);
            end
        end

        hold_input();
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (board.mismatches == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    // Run limit: well above a run of back-to-back full-list sorts
    initial begin
        #300000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
